// File: sv/scwt_pkg.sv
package scwt_pkg;

    // Field and register widths
    localparam int MAX_FRAME_DIM_DEF = 4096;
    localparam int DIM_REG_W  = 13;
    localparam int FACTOR_W   = 17;
    localparam int ZOOM_W     = 16;
    localparam int POS_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int FRAC_W     = 17;
    localparam int CROP_POS_W = 13;
    localparam int CROP_LEN_W = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int PC_W       = 5;

    // Fixed-point constants
    localparam logic [FACTOR_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [FRAC_W-1:0]   FRAC_MAX   = 17'h1FFFF;
    localparam logic [ZOOM_W-1:0]   ZOOM_MAX   = 16'hFFFF;
    localparam logic [ZOOM_W-1:0]   ZOOM_MIN   = 16'd1;
    localparam int                  ROUND_HALF = 32768;
    localparam int                  CTR_SHIFT  = 15;
    localparam int                  ZOOM_FRAC  = 12;
    localparam int                  Q16_SHIFT  = 16;

    // Reset values
    localparam logic [DIM_REG_W-1:0] FRAME_WIDTH_RST  = 13'd1280;
    localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RST = 13'd720;
    localparam logic [FACTOR_W-1:0]  SMOOTHING_RST    = 17'd6554;
    localparam logic [ZOOM_W-1:0]    ZOOM_BASE_RST    = 16'd4096;
    localparam logic [ZOOM_W-1:0]    ZOOM_MUL_RST     = 16'd4096;
    localparam logic [FRAC_W-1:0]    CENTER_RST       = 17'd32768;
    localparam logic [ZOOM_W-1:0]    ZOOM_LEVEL_RST   = 16'd6144;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH     = 3'd0,
        REG_FRAME_HEIGHT    = 3'd1,
        REG_SMOOTHING       = 3'd2,
        REG_ZOOM_BASE       = 3'd3,
        REG_ZOOM_MULTIPLIER = 3'd4
    } cfg_reg_t;

    // Micro-operations driving the datapath
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_DIV_CTR,
        OP_MUL_CTR,
        OP_UPD_CTR,
        OP_MUL_SIDE,
        OP_DIV_ZM,
        OP_ZMEAS,
        OP_MUL_ZM,
        OP_UPD_ZM,
        OP_DIV_CROP,
        OP_MUL_CPIX,
        OP_EDGE,
        OP_LEN,
        OP_EMIT
    } uop_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_NO_FACE,
        C_DIV_BUSY,
        C_OUT_FULL
    } jcond_t;

    typedef struct packed {
        uop_t            op;
        logic            axis_y;
        jcond_t          cond;
        logic [PC_W-1:0] target;
    } uword_t;

    localparam logic [PC_W-1:0] L_IDLE = 5'd0;
    localparam logic [PC_W-1:0] L_CROP = 5'd16;

    function automatic uword_t mk_uword(input uop_t op, input logic ay, input jcond_t c,
                                        input logic [PC_W-1:0] t);
        uword_t w;
        w.op     = op;
        w.axis_y = ay;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    // Microcode ROM: wait steps loop on their own address
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            5'd0:  w = mk_uword(OP_ACCEPT,   1'b0, C_NO_IN,    L_IDLE);
            5'd1:  w = mk_uword(OP_NOP,      1'b0, C_NO_FACE,  L_CROP);
            5'd2:  w = mk_uword(OP_DIV_CTR,  1'b0, C_NEVER,    L_IDLE);
            5'd3:  w = mk_uword(OP_NOP,      1'b0, C_DIV_BUSY, pc);
            5'd4:  w = mk_uword(OP_MUL_CTR,  1'b0, C_NEVER,    L_IDLE);
            5'd5:  w = mk_uword(OP_UPD_CTR,  1'b0, C_NEVER,    L_IDLE);
            5'd6:  w = mk_uword(OP_DIV_CTR,  1'b1, C_NEVER,    L_IDLE);
            5'd7:  w = mk_uword(OP_NOP,      1'b1, C_DIV_BUSY, pc);
            5'd8:  w = mk_uword(OP_MUL_CTR,  1'b1, C_NEVER,    L_IDLE);
            5'd9:  w = mk_uword(OP_UPD_CTR,  1'b1, C_NEVER,    L_IDLE);
            5'd10: w = mk_uword(OP_MUL_SIDE, 1'b0, C_NEVER,    L_IDLE);
            5'd11: w = mk_uword(OP_DIV_ZM,   1'b0, C_NEVER,    L_IDLE);
            5'd12: w = mk_uword(OP_NOP,      1'b0, C_DIV_BUSY, pc);
            5'd13: w = mk_uword(OP_ZMEAS,    1'b0, C_NEVER,    L_IDLE);
            5'd14: w = mk_uword(OP_MUL_ZM,   1'b0, C_NEVER,    L_IDLE);
            5'd15: w = mk_uword(OP_UPD_ZM,   1'b0, C_NEVER,    L_IDLE);
            5'd16: w = mk_uword(OP_DIV_CROP, 1'b0, C_NEVER,    L_IDLE);
            5'd17: w = mk_uword(OP_NOP,      1'b0, C_DIV_BUSY, pc);
            5'd18: w = mk_uword(OP_MUL_CPIX, 1'b0, C_NEVER,    L_IDLE);
            5'd19: w = mk_uword(OP_EDGE,     1'b0, C_NEVER,    L_IDLE);
            5'd20: w = mk_uword(OP_LEN,      1'b0, C_NEVER,    L_IDLE);
            5'd21: w = mk_uword(OP_DIV_CROP, 1'b1, C_NEVER,    L_IDLE);
            5'd22: w = mk_uword(OP_NOP,      1'b1, C_DIV_BUSY, pc);
            5'd23: w = mk_uword(OP_MUL_CPIX, 1'b1, C_NEVER,    L_IDLE);
            5'd24: w = mk_uword(OP_EDGE,     1'b1, C_NEVER,    L_IDLE);
            5'd25: w = mk_uword(OP_LEN,      1'b1, C_NEVER,    L_IDLE);
            5'd26: w = mk_uword(OP_EMIT,     1'b0, C_OUT_FULL, pc);
            default: w = mk_uword(OP_NOP,    1'b0, C_ALWAYS,   L_IDLE);
        endcase
        return w;
    endfunction

endpackage

// File: sv/scwt_div.sv
// Restoring divider, one quotient bit per cycle
module scwt_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    cnt_reg;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fit;

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;

    // Shift next numerator bit into the remainder and try the subtract
    always_comb begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        fit      = (trial >= {1'b0, den_reg});
        quo_next = {quo_reg[NUM_W-2:0], fit};
        rem_next = fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CW'(NUM_W);
        end else if (busy) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// File: sv/smoothed_crop_window_tracker.sv
// Tracks a smoothed crop window from one face rectangle per video frame and
// returns one crop rectangle per frame. A short microcode program steps a
// small datapath: one 18-bit multiplier and a shared restoring divider that
// yields one quotient bit per cycle of its 30-bit quotient, and the program
// waits on each division. The divider sets the pace: a frame with a face
// needs five divisions and a frame without a face needs two. One frame is
// worked on at a time; a finished result sits in the output register while
// the next frame is accepted. Configuration writes are always taken and
// should only be issued while the block is idle.
module smoothed_crop_window_tracker
    import scwt_pkg::*;
#(
    parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    // face input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_face_present,
    input  logic [POS_W-1:0]             s_face_left,
    input  logic [POS_W-1:0]             s_face_top,
    input  logic [SIZE_W-1:0]            s_face_w,
    input  logic [SIZE_W-1:0]            s_face_h,
    // crop output channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [CROP_POS_W-1:0]        m_crop_left,
    output logic [CROP_POS_W-1:0]        m_crop_top,
    output logic signed [CROP_LEN_W-1:0] m_crop_w,
    output logic signed [CROP_LEN_W-1:0] m_crop_h,
    output logic                         m_crop_valid
);

    localparam int DW   = $clog2(MAX_FRAME_DIM + 1);
    localparam int CMPW = (DW > DIM_REG_W) ? DW : DIM_REG_W;
    localparam int CNW  = 2 * POS_W - 9 + CTR_SHIFT;   // centre numerator bits
    localparam int NW   = (CNW > DW + ZOOM_FRAC) ? CNW : DW + ZOOM_FRAC;
    localparam int DENW = (DW > ZOOM_W) ? DW : ZOOM_W;
    localparam int MBW  = (DW + 1 > 18) ? DW + 1 : 18;
    localparam int PW   = 18 + MBW;
    localparam int SW   = NW + 1;
    localparam int LW   = DW + 2;

    // Configuration registers
    logic [DIM_REG_W-1:0] frame_width_reg, frame_height_reg;
    logic [FACTOR_W-1:0]  smoothing_reg;
    logic [ZOOM_W-1:0]    zoom_base_reg, zoom_mul_reg;

    // Tracker state
    logic [FRAC_W-1:0] cx_reg, cy_reg;
    logic [ZOOM_W-1:0] zoom_reg;

    // Sequencer
    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          uw;
    logic            jump;

    // Latched input
    logic              face_reg;
    logic [POS_W-1:0]  fl_reg, ft_reg;
    logic [SIZE_W-1:0] fw_reg, fh_reg;

    // Datapath working registers
    logic signed [PW-1:0] prod_reg, prod_next;
    logic [ZOOM_W-1:0]    zmeas_reg, zmeas_next;
    logic [NW-2:0]        half_reg;
    logic [DW:0]          lo_reg, lo_next;
    logic [DW-1:0]        hi_reg, hi_next;
    logic [DW:0]          left_reg, top_reg;
    logic signed [LW-1:0] lenx_reg, leny_reg, len_next;

    // Output register
    logic                         m_valid_reg;
    logic [CROP_POS_W-1:0]        crop_left_reg, crop_top_reg;
    logic signed [CROP_LEN_W-1:0] crop_w_reg, crop_h_reg;
    logic                         crop_valid_reg;
    logic                         out_full;

    // Divider interface
    logic            div_start, div_busy;
    logic [NW-1:0]   div_num, div_quo;
    logic [DENW-1:0] div_den;

    // Combinational helpers
    logic [CMPW-1:0]         fw_ext, fh_ext;
    logic [DW-1:0]           wf, hf, dim_sel;
    logic [FACTOR_W-1:0]     a_eff;
    logic [POS_W-1:0]        pos_sel;
    logic [SIZE_W-1:0]       size_sel, side;
    logic [FRAC_W-1:0]       frac_sel, ctr_meas, ctr_next;
    logic [CNW-CTR_SHIFT-1:0] ctr_sum;
    logic signed [17:0]      blend_d;
    logic signed [17:0]      mul_a;
    logic signed [MBW-1:0]   mul_b;
    logic signed [PW-1:0]    rnd_sum, inc;
    logic [ZOOM_W-1:0]       zoom_sum;
    logic [ZOOM_W-1:0]       zoom_next;
    logic [NW:0]             zsum;
    logic [DW:0]             cpix;
    logic signed [SW-1:0]    lo_s;
    logic [SW-1:0]           hi_s;

    assign cfg_ready = 1'b1;
    assign uw        = ucode(pc_reg);
    assign s_ready   = (uw.op == OP_ACCEPT);
    assign out_full  = m_valid_reg && !m_ready;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            smoothing_reg    <= SMOOTHING_RST;
            zoom_base_reg    <= ZOOM_BASE_RST;
            zoom_mul_reg     <= ZOOM_MUL_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_WIDTH:     frame_width_reg  <= cfg_data[DIM_REG_W-1:0];
                REG_FRAME_HEIGHT:    frame_height_reg <= cfg_data[DIM_REG_W-1:0];
                REG_SMOOTHING:       smoothing_reg    <= cfg_data[FACTOR_W-1:0];
                REG_ZOOM_BASE:       zoom_base_reg    <= cfg_data[ZOOM_W-1:0];
                REG_ZOOM_MULTIPLIER: zoom_mul_reg     <= cfg_data[ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size, factor clamp and per-axis selection
    always_comb begin
        fw_ext = CMPW'(frame_width_reg);
        fh_ext = CMPW'(frame_height_reg);
        if (fw_ext == '0) begin
            wf = DW'(1);
        end else if (fw_ext > CMPW'(MAX_FRAME_DIM)) begin
            wf = DW'(MAX_FRAME_DIM);
        end else begin
            wf = DW'(fw_ext);
        end
        if (fh_ext == '0) begin
            hf = DW'(1);
        end else if (fh_ext > CMPW'(MAX_FRAME_DIM)) begin
            hf = DW'(MAX_FRAME_DIM);
        end else begin
            hf = DW'(fh_ext);
        end
        a_eff    = (smoothing_reg > ONE_Q16) ? ONE_Q16 : smoothing_reg;
        dim_sel  = uw.axis_y ? hf : wf;
        pos_sel  = uw.axis_y ? ft_reg : fl_reg;
        size_sel = uw.axis_y ? fh_reg : fw_reg;
        frac_sel = uw.axis_y ? cy_reg : cx_reg;
        side     = (fw_reg > fh_reg) ? fw_reg : fh_reg;
        ctr_sum  = {1'b0, pos_sel, 1'b0} + {1'b0, size_sel};
    end

    // Divider operands
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = DENW'(wf);
        case (uw.op)
            OP_DIV_CTR: begin
                div_start = 1'b1;
                div_num   = NW'({ctr_sum, {CTR_SHIFT{1'b0}}});
                div_den   = DENW'(dim_sel);
            end
            OP_DIV_ZM: begin
                div_start = 1'b1;
                div_num   = NW'(prod_reg[SIZE_W+ZOOM_W-1:0]);
                div_den   = DENW'(wf);
            end
            OP_DIV_CROP: begin
                div_start = 1'b1;
                div_num   = NW'({dim_sel, {ZOOM_FRAC{1'b0}}});
                div_den   = DENW'(zoom_reg);
            end
            default: ;
        endcase
    end

    scwt_div #(
        .NUM_W (NW),
        .DEN_W (DENW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    // Measurements and smoothing arithmetic
    always_comb begin
        ctr_meas   = (div_quo > NW'(FRAC_MAX)) ? FRAC_MAX : div_quo[FRAC_W-1:0];
        zsum       = (NW+1)'(zoom_base_reg) + {1'b0, div_quo};
        zmeas_next = (zsum > (NW+1)'(ZOOM_MAX)) ? ZOOM_MAX : zsum[ZOOM_W-1:0];
        if (uw.op == OP_MUL_ZM) begin
            blend_d = $signed({2'b00, zmeas_reg}) - $signed({2'b00, zoom_reg});
        end else begin
            blend_d = $signed({1'b0, ctr_meas}) - $signed({1'b0, frac_sel});
        end
        case (uw.op)
            OP_MUL_SIDE: begin
                mul_a = $signed(18'(side));
                mul_b = $signed(MBW'(zoom_mul_reg));
            end
            OP_MUL_CPIX: begin
                mul_a = $signed({1'b0, frac_sel});
                mul_b = $signed(MBW'(dim_sel));
            end
            default: begin
                mul_a = $signed({1'b0, a_eff});
                mul_b = MBW'(blend_d);
            end
        endcase
        prod_next = PW'(mul_a) * PW'(mul_b);
        // old + floor((a*(meas-old) + half) / 2^16)
        rnd_sum   = prod_reg + $signed(PW'(ROUND_HALF));
        inc       = rnd_sum >>> Q16_SHIFT;
        ctr_next  = frac_sel + inc[FRAC_W-1:0];
        zoom_sum  = zoom_reg + inc[ZOOM_W-1:0];
        zoom_next = (zoom_sum == '0) ? ZOOM_MIN : zoom_sum;
    end

    // Crop edges on one axis
    always_comb begin
        cpix     = prod_reg[Q16_SHIFT +: DW+1];
        lo_s     = $signed(SW'(cpix)) - $signed(SW'(half_reg));
        hi_s     = SW'(cpix) + SW'(half_reg);
        lo_next  = (lo_s < 0) ? '0 : lo_s[DW:0];
        hi_next  = (hi_s > SW'(dim_sel)) ? dim_sel : hi_s[DW-1:0];
        len_next = $signed({2'b00, hi_reg}) - $signed({1'b0, lo_reg});
    end

    // Step counter with conditional jumps
    always_comb begin
        case (uw.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_IN:    jump = !s_valid;
            C_NO_FACE:  jump = !face_reg;
            C_DIV_BUSY: jump = div_busy;
            C_OUT_FULL: jump = out_full;
            default:    jump = 1'b1;
        endcase
        pc_next = jump ? uw.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= L_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // Kept centre and zoom
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg   <= CENTER_RST;
            cy_reg   <= CENTER_RST;
            zoom_reg <= ZOOM_LEVEL_RST;
        end else begin
            case (uw.op)
                OP_UPD_CTR: begin
                    if (uw.axis_y) begin
                        cy_reg <= ctr_next;
                    end else begin
                        cx_reg <= ctr_next;
                    end
                end
                OP_UPD_ZM: zoom_reg <= zoom_next;
                default: ;
            endcase
        end
    end

    // Working registers and input latch
    always_ff @(posedge aclk) begin
        case (uw.op)
            OP_ACCEPT: begin
                if (s_valid) begin
                    face_reg <= s_face_present;
                    fl_reg   <= s_face_left;
                    ft_reg   <= s_face_top;
                    fw_reg   <= s_face_w;
                    fh_reg   <= s_face_h;
                end
            end
            OP_MUL_CTR, OP_MUL_SIDE, OP_MUL_ZM: prod_reg <= prod_next;
            OP_MUL_CPIX: begin
                prod_reg <= prod_next;
                half_reg <= div_quo[NW-1:1];
            end
            OP_ZMEAS: zmeas_reg <= zmeas_next;
            OP_EDGE: begin
                lo_reg <= lo_next;
                hi_reg <= hi_next;
            end
            OP_LEN: begin
                if (uw.axis_y) begin
                    top_reg  <= lo_reg;
                    leny_reg <= len_next;
                end else begin
                    left_reg <= lo_reg;
                    lenx_reg <= len_next;
                end
            end
            OP_EMIT: begin
                if (!out_full) begin
                    crop_left_reg  <= CROP_POS_W'(left_reg);
                    crop_top_reg   <= CROP_POS_W'(top_reg);
                    crop_w_reg     <= CROP_LEN_W'(lenx_reg);
                    crop_h_reg     <= CROP_LEN_W'(leny_reg);
                    crop_valid_reg <= (lenx_reg > 0) && (leny_reg > 0);
                end
            end
            default: ;
        endcase
    end

    // Output valid: set on emit, cleared on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((uw.op == OP_EMIT) && !out_full) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_crop_left  = crop_left_reg;
    assign m_crop_top   = crop_top_reg;
    assign m_crop_w     = crop_w_reg;
    assign m_crop_h     = crop_h_reg;
    assign m_crop_valid = crop_valid_reg;

endmodule

// File: verif/tb_smoothed_crop_window_tracker.sv
module tb_smoothed_crop_window_tracker;
    import scwt_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int FRAME_DIM_MAX = MAX_FRAME_DIM_DEF;
    localparam int IDLE_PCT      = 8;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 400;
    localparam int RANDOM_FRAMES = 2000;
    localparam int PHASE_FRAMES  = 250;
    localparam int TIMEOUT_TICKS = 40_000_000;

    typedef struct {
        logic              present;
        logic [POS_W-1:0]  left;
        logic [POS_W-1:0]  top;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } frame_t;

    typedef struct {
        logic [CROP_POS_W-1:0]        left;
        logic [CROP_POS_W-1:0]        top;
        logic signed [CROP_LEN_W-1:0] w;
        logic signed [CROP_LEN_W-1:0] h;
        logic                         ok;
    } crop_t;

    // Tracker state and register copy, plus the crops still owed by the block
    class crop_scoreboard;
        logic [DIM_REG_W-1:0] frame_width;
        logic [DIM_REG_W-1:0] frame_height;
        logic [FACTOR_W-1:0]  smoothing;
        logic [ZOOM_W-1:0]    zoom_base;
        logic [ZOOM_W-1:0]    zoom_mul;
        logic [FRAC_W-1:0]    centre_x;
        logic [FRAC_W-1:0]    centre_y;
        logic [ZOOM_W-1:0]    zoom;
        crop_t                expected_crops[$];
        int                   errors;

        function new();
            frame_width  = FRAME_WIDTH_RST;
            frame_height = FRAME_HEIGHT_RST;
            smoothing    = SMOOTHING_RST;
            zoom_base    = ZOOM_BASE_RST;
            zoom_mul     = ZOOM_MUL_RST;
            centre_x     = CENTER_RST;
            centre_y     = CENTER_RST;
            zoom         = ZOOM_LEVEL_RST;
            errors       = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:     frame_width  = data[DIM_REG_W-1:0];
                REG_FRAME_HEIGHT:    frame_height = data[DIM_REG_W-1:0];
                REG_SMOOTHING:       smoothing    = data[FACTOR_W-1:0];
                REG_ZOOM_BASE:       zoom_base    = data[ZOOM_W-1:0];
                REG_ZOOM_MULTIPLIER: zoom_mul     = data[ZOOM_W-1:0];
                default: ;
            endcase
        endfunction

        // Zero is taken as one, oversize as the frame limit
        function longint unsigned clamp_dim(logic [DIM_REG_W-1:0] r);
            longint unsigned d;
            d = r;
            if (d < 1) d = 1;
            if (d > FRAME_DIM_MAX) d = FRAME_DIM_MAX;
            return d;
        endfunction

        // Exponential smoothing, rounded half up; weight capped at one
        function longint unsigned smooth(longint unsigned meas, longint unsigned old);
            longint unsigned a;
            a = (smoothing > 65536) ? 65536 : smoothing;
            return (a * meas + (65536 - a) * old + 32768) >> 16;
        endfunction

        // Normalised centre in Q1.16, saturating at the 17-bit maximum
        function longint unsigned centre_ratio(longint unsigned pos, longint unsigned size,
                                               longint unsigned dim);
            longint unsigned q;
            q = ((2 * pos + size) << 15) / dim;
            return (q > 131071) ? 131071 : q;
        endfunction

        // One axis of the crop: size from zoom, centred, clamped to the frame
        function void place_axis(longint unsigned frac, longint unsigned dim,
                                 output logic [CROP_POS_W-1:0] lo,
                                 output logic signed [CROP_LEN_W-1:0] len,
                                 output logic pos);
            longint unsigned span;
            longint half, mid, a, b, diff;
            span = (dim << 12) / zoom;
            half = longint'(span / 2);
            mid  = longint'((frac * dim) >> 16);
            a = mid - half;
            b = mid + half;
            if (a < 0) a = 0;
            if (b > longint'(dim)) b = longint'(dim);
            diff = b - a;
            lo  = a[CROP_POS_W-1:0];
            len = diff[CROP_LEN_W-1:0];
            pos = (diff > 0);
        endfunction

        function void note_frame(frame_t f);
            longint unsigned wf, hf, side, zm, z;
            crop_t c;
            logic okx, oky;
            wf = clamp_dim(frame_width);
            hf = clamp_dim(frame_height);
            // no face: state held, crop still reported
            if (f.present) begin
                centre_x = FRAC_W'(smooth(centre_ratio(f.left, f.w, wf), centre_x));
                centre_y = FRAC_W'(smooth(centre_ratio(f.top, f.h, hf), centre_y));
                side = (f.w > f.h) ? f.w : f.h;
                zm = zoom_base + (side * zoom_mul) / wf;
                if (zm > 65535) zm = 65535;
                z = smooth(zm, zoom);
                if (z > 65535) z = 65535;
                if (z < 1) z = 1;
                zoom = z[ZOOM_W-1:0];
            end
            place_axis(centre_x, wf, c.left, c.w, okx);
            place_axis(centre_y, hf, c.top, c.h, oky);
            c.ok = okx && oky;
            expected_crops = {expected_crops, c};
        endfunction

        task check_crop(crop_t got);
            crop_t want;
            if (expected_crops.size() == 0) begin
                report("crop transfer with no frame outstanding");
                return;
            end
            want = expected_crops.pop_front();
            if (got.left !== want.left)
                report($sformatf("crop_left got %0d expected %0d", got.left, want.left));
            if (got.top !== want.top)
                report($sformatf("crop_top got %0d expected %0d", got.top, want.top));
            if (got.w !== want.w)
                report($sformatf("crop_w got %0d expected %0d", got.w, want.w));
            if (got.h !== want.h)
                report($sformatf("crop_h got %0d expected %0d", got.h, want.h));
            if (got.ok !== want.ok)
                report($sformatf("crop_valid got %0b expected %0b", got.ok, want.ok));
        endtask

        function int pending();
            return expected_crops.size();
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data  = '0;

    logic                         s_valid        = 1'b0;
    logic                         s_ready;
    logic                         s_face_present = 1'b0;
    logic [POS_W-1:0]             s_face_left    = '0;
    logic [POS_W-1:0]             s_face_top     = '0;
    logic [SIZE_W-1:0]            s_face_w       = '0;
    logic [SIZE_W-1:0]            s_face_h       = '0;

    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [CROP_POS_W-1:0]        m_crop_left;
    logic [CROP_POS_W-1:0]        m_crop_top;
    logic signed [CROP_LEN_W-1:0] m_crop_w;
    logic signed [CROP_LEN_W-1:0] m_crop_h;
    logic                         m_crop_valid;

    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    bit hold_start = 1'b0;

    crop_scoreboard sb = new();
    crop_t          seen_crop;

    smoothed_crop_window_tracker DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_face_present (s_face_present),
        .s_face_left    (s_face_left),
        .s_face_top     (s_face_top),
        .s_face_w       (s_face_w),
        .s_face_h       (s_face_h),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_crop_left    (m_crop_left),
        .m_crop_top     (m_crop_top),
        .m_crop_w       (m_crop_w),
        .m_crop_h       (m_crop_h),
        .m_crop_valid   (m_crop_valid)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Watchdog
    initial begin
        #(TIMEOUT_TICKS);
        $display("Verification failed");
        $finish;
    end

    // Crop receiver: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_start) begin
                hold_start = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= !(rx_idle_en && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Crop monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_crop.left = m_crop_left;
            seen_crop.top  = m_crop_top;
            seen_crop.w    = m_crop_w;
            seen_crop.h    = m_crop_h;
            seen_crop.ok   = m_crop_valid;
            sb.check_crop(seen_crop);
        end
    end

    function automatic frame_t make_frame(logic present, int left, int top, int w, int h);
        frame_t f;
        f.present = present;
        f.left    = left[POS_W-1:0];
        f.top     = top[POS_W-1:0];
        f.w       = w[SIZE_W-1:0];
        f.h       = h[SIZE_W-1:0];
        return f;
    endfunction

    // Mostly faces inside the effective frame; the rest anywhere in field range
    function automatic frame_t random_frame();
        frame_t f;
        int wf, hf;
        wf = int'(sb.clamp_dim(sb.frame_width));
        hf = int'(sb.clamp_dim(sb.frame_height));
        f.present = ($urandom_range(99) < 75);
        if ($urandom_range(99) < 80) begin
            f.left = POS_W'($urandom_range(0, wf - 1));
            f.top  = POS_W'($urandom_range(0, hf - 1));
            f.w    = SIZE_W'($urandom_range(0, wf - int'(f.left)));
            f.h    = SIZE_W'($urandom_range(0, hf - int'(f.top)));
        end else begin
            f.left = POS_W'($urandom_range(0, 4095));
            f.top  = POS_W'($urandom_range(0, 4095));
            f.w    = SIZE_W'($urandom_range(0, 4096));
            f.h    = SIZE_W'($urandom_range(0, 4096));
        end
        return f;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(15))
            0: return '0;
            1: return CFG_DATA_W'(1);
            2: return CFG_DATA_W'(FRAME_DIM_MAX);
            3: return CFG_DATA_W'($urandom_range(FRAME_DIM_MAX + 1, 131071));
            default: return CFG_DATA_W'($urandom_range(64, FRAME_DIM_MAX));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_factor();
        case ($urandom_range(11))
            0: return '0;
            1: return CFG_DATA_W'(65536);
            2: return CFG_DATA_W'($urandom_range(65537, 131071));
            3: return CFG_DATA_W'($urandom_range(1, 1000));
            default: return CFG_DATA_W'($urandom_range(1000, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_zoom();
        case ($urandom_range(9))
            0: return '0;
            1: return CFG_DATA_W'(65535);
            2: return CFG_DATA_W'($urandom_range(0, 65535));
            default: return CFG_DATA_W'($urandom_range(2048, 12288));
        endcase
    endfunction

    // One face transfer, with random idle cycles ahead of it
    task automatic send_frame(frame_t f);
        while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_face_present <= f.present;
        s_face_left    <= f.left;
        s_face_top     <= f.top;
        s_face_w       <= f.w;
        s_face_h       <= f.h;
        do @(posedge aclk); while (!s_ready);
        sb.note_frame(f);
    endtask

    // Sender stops until every crop owed has been taken
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // All registers rewritten once the block has gone quiet; sometimes a stray index too
    task automatic configure(logic [CFG_DATA_W-1:0] fw, logic [CFG_DATA_W-1:0] fh,
                             logic [CFG_DATA_W-1:0] sf, logic [CFG_DATA_W-1:0] zb,
                             logic [CFG_DATA_W-1:0] zmul);
        logic [CFG_IDX_W-1:0] stray;
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if ($urandom_range(1)) begin
            stray = REG_ZOOM_MULTIPLIER;
            stray = stray + CFG_IDX_W'($urandom_range(1, 3));
            write_reg(stray, CFG_DATA_W'($urandom_range(0, 131071)));
        end
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_SMOOTHING, sf);
        write_reg(REG_ZOOM_BASE, zb);
        write_reg(REG_ZOOM_MULTIPLIER, zmul);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, no-face frames and field extremes
        send_frame(make_frame(1'b0, 0, 0, 0, 0));
        send_frame(make_frame(1'b0, 4095, 4095, 4096, 4096));
        send_frame(make_frame(1'b1, 640, 360, 200, 150));
        send_frame(make_frame(1'b1, 0, 0, 0, 0));
        send_frame(make_frame(1'b1, 4095, 4095, 4096, 4096));
        send_frame(make_frame(1'b1, 4095, 0, 0, 4096));

        // zero width, oversize height, weight above one, zoom overflow
        configure(17'd0, 17'h1FFFF, 17'd131071, 17'd65535, 17'd65535);
        send_frame(make_frame(1'b1, 100, 100, 4096, 10));
        send_frame(make_frame(1'b1, 0, 4095, 4096, 4096));
        send_frame(make_frame(1'b0, 1, 2, 3, 4));
        send_frame(make_frame(1'b1, 2048, 2048, 4096, 4096));

        // full weight with zero zoom measurement: kept zoom floors at one
        configure(CFG_DATA_W'(FRAME_DIM_MAX), 17'd1, 17'd65536, 17'd0, 17'd0);
        send_frame(make_frame(1'b1, 1000, 0, 50, 1));
        send_frame(make_frame(1'b1, 4095, 0, 1, 0));
        send_frame(make_frame(1'b0, 0, 0, 0, 0));

        // zero weight: state frozen even with faces
        configure(17'd1, CFG_DATA_W'(FRAME_DIM_MAX), 17'd0, 17'd65535, 17'd1);
        send_frame(make_frame(1'b1, 0, 0, 1, 1));
        send_frame(make_frame(1'b1, 4095, 4095, 4096, 0));

        // upper data bits above the register width are dropped
        configure(17'h1E005, 17'd2000, 17'd32768, 17'd4096, 17'd8192);
        send_frame(make_frame(1'b1, 2, 2, 1, 1));
        send_frame(make_frame(1'b1, 3, 1500, 2, 400));
        send_frame(make_frame(1'b0, 0, 0, 0, 0));

        configure(17'd1280, 17'd720, 17'd6554, 17'd4096, 17'd4096);
        send_frame(make_frame(1'b1, 600, 300, 120, 160));
        send_frame(make_frame(1'b1, 610, 310, 118, 158));
        drain();

        // random phases, fresh settings for each
        for (int phase = 0; phase < RANDOM_FRAMES / PHASE_FRAMES; phase++) begin
            if (phase > 0)
                configure(pick_dim(), pick_dim(), pick_factor(), pick_zoom(), pick_zoom());
            // phase 1 runs with no idling on either side
            tx_idle_en = (phase != 1);
            rx_idle_en = (phase != 1);
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                if (phase == 2 && n == 10) hold_start = 1'b1;
                if (phase == 4 && n == 100) drain();
                send_frame(random_frame());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
